[hw/rtl/idsc_pkg.sv]
// ----------------------------------------------------------------------------
// idsc_pkg
// Shared constants, types and the Gaussian weight function of the image
// block downscaler.
// ----------------------------------------------------------------------------
package idsc_pkg;

   localparam int MAX_WIDTH       = 4096;
   localparam int MAX_OUT_COLUMNS = 2048;
   localparam int SUM_BITS        = 20;

   localparam int PIX_BITS     = 8;
   localparam int OUT_POS_BITS = 11;
   localparam int FACTOR_BITS  = 5;
   localparam int SIZE_BITS    = 13;
   localparam int LANES        = 3;

   localparam int POS_BITS = $clog2(MAX_WIDTH);
   localparam int OC_BITS  = $clog2(MAX_OUT_COLUMNS);

   localparam int FACTOR_MIN   = 2;
   localparam int FACTOR_MAX   = 16;
   localparam int FACTOR_RESET = 2;
   localparam int REM_BITS     = $clog2(FACTOR_MAX);
   localparam int GAUSS_DIV    = 16;
   localparam int SHIFT_BITS   = 2;

   // compare width that holds any position or size plus twice the factor
   localparam int CMP_BITS = ((POS_BITS > SIZE_BITS) ? POS_BITS : SIZE_BITS) + 2;

   // shared divider: dividend covers both a channel sum and a position
   localparam int DIV_BITS = (SUM_BITS > POS_BITS) ? SUM_BITS : POS_BITS;
   localparam int DVS_BITS = $clog2(FACTOR_MAX * FACTOR_MAX + 1);
   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = SIZE_BITS;

   localparam int REQ_DATA_BITS = 3 * PIX_BITS;
   localparam int RSP_DATA_BITS = ((3 * PIX_BITS + 2 * OUT_POS_BITS + 7) / 8) * 8;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_SCALE_FACTOR,
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT,
      REG_COLOR_MODE
   } csr_index_type;

   // settled configuration: factor and sizes already clamped
   typedef struct packed {
      logic [FACTOR_BITS-1:0] factor;
      logic [SIZE_BITS-1:0]   width;
      logic [SIZE_BITS-1:0]   height;
      logic                   rgb;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic upd;
      logic fix_start;
      logic fix_load;
   } cmd_type;

   typedef struct packed {
      logic block_done;
      logic div_done;
   } sts_type;

   typedef struct packed {
      logic [PIX_BITS-1:0]     red;
      logic [PIX_BITS-1:0]     green;
      logic [PIX_BITS-1:0]     blue;
      logic [OUT_POS_BITS-1:0] column;
      logic [OUT_POS_BITS-1:0] row;
      logic                    row_end;
   } rsp_type;

   // 1-2-1 kernel as a left shift: weight 1, 2 or 4 by row and column mod 3
   function automatic logic [SHIFT_BITS-1:0] gauss_shift(input logic [1:0] row_m3,
                                                         input logic [1:0] col_m3);
      logic [SHIFT_BITS-1:0] s;
      s = '0;
      if (row_m3 == 2'd1) s = s + SHIFT_BITS'(1);
      if (col_m3 == 2'd1) s = s + SHIFT_BITS'(1);
      return s;
   endfunction

endpackage

[hw/rtl/idsc_csr.sv]
// ----------------------------------------------------------------------------
// idsc_csr
// Configuration registers with clamping, and the flag that asks for the
// position quotients to be realigned after a factor change.
// ----------------------------------------------------------------------------
module idsc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [idsc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [idsc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                 fix_start,
   output idsc_pkg::cfg_type                    cfg,
   output logic                                 dirty
);

   logic [idsc_pkg::FACTOR_BITS-1:0] factor_ff, factor_in;
   logic [idsc_pkg::SIZE_BITS-1:0]   width_ff, width_in;
   logic [idsc_pkg::SIZE_BITS-1:0]   height_ff, height_in;
   logic                             rgb_ff, rgb_in;
   logic                             dirty_ff, dirty_in;
   logic                             wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_comb begin
      factor_in = factor_ff;
      width_in  = width_ff;
      height_in = height_ff;
      rgb_in    = rgb_ff;
      dirty_in  = dirty_ff & ~fix_start;
      if (wr) begin
         case (idsc_pkg::csr_index_type'(csr_index))
            idsc_pkg::REG_SCALE_FACTOR: begin
               factor_in = csr_wdata[idsc_pkg::FACTOR_BITS-1:0];
               dirty_in  = 1'b1;
            end
            idsc_pkg::REG_IMAGE_WIDTH:  width_in  = csr_wdata;
            idsc_pkg::REG_IMAGE_HEIGHT: height_in = csr_wdata;
            idsc_pkg::REG_COLOR_MODE:   rgb_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= idsc_pkg::FACTOR_BITS'(idsc_pkg::FACTOR_RESET);
         width_ff  <= idsc_pkg::SIZE_BITS'(idsc_pkg::MAX_WIDTH);
         height_ff <= idsc_pkg::SIZE_BITS'(idsc_pkg::MAX_WIDTH);
         rgb_ff    <= 1'b0;
         dirty_ff  <= 1'b0;
      end else begin
         factor_ff <= factor_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         rgb_ff    <= rgb_in;
         dirty_ff  <= dirty_in;
      end
   end

   // clamp factor to its range, sizes to 1..MAX_WIDTH
   always_comb begin
      if (32'(factor_ff) < idsc_pkg::FACTOR_MIN)
         cfg.factor = idsc_pkg::FACTOR_BITS'(idsc_pkg::FACTOR_MIN);
      else if (32'(factor_ff) > idsc_pkg::FACTOR_MAX)
         cfg.factor = idsc_pkg::FACTOR_BITS'(idsc_pkg::FACTOR_MAX);
      else
         cfg.factor = factor_ff;

      if (width_ff == '0)
         cfg.width = idsc_pkg::SIZE_BITS'(1);
      else if (32'(width_ff) > idsc_pkg::MAX_WIDTH)
         cfg.width = idsc_pkg::SIZE_BITS'(idsc_pkg::MAX_WIDTH);
      else
         cfg.width = width_ff;

      if (height_ff == '0)
         cfg.height = idsc_pkg::SIZE_BITS'(1);
      else if (32'(height_ff) > idsc_pkg::MAX_WIDTH)
         cfg.height = idsc_pkg::SIZE_BITS'(idsc_pkg::MAX_WIDTH);
      else
         cfg.height = height_ff;

      cfg.rgb = rgb_ff;
   end

   assign dirty = dirty_ff;

endmodule

[hw/rtl/idsc_div.sv]
// ----------------------------------------------------------------------------
// idsc_div
// Three-lane restoring divider with a common divisor, one quotient bit per
// cycle. Quotient and remainder hold until the next start.
// ----------------------------------------------------------------------------
module idsc_div (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    start,
   input  logic [idsc_pkg::LANES-1:0][idsc_pkg::DIV_BITS-1:0]      dividend,
   input  logic [idsc_pkg::DVS_BITS-1:0]                           divisor,
   output logic [idsc_pkg::LANES-1:0][idsc_pkg::DIV_BITS-1:0]      quotient,
   output logic [idsc_pkg::LANES-1:0][idsc_pkg::DVS_BITS-1:0]      remainder,
   output logic                                                    done
);

   logic [idsc_pkg::LANES-1:0][idsc_pkg::DIV_BITS-1:0] quo_ff, quo_in;
   logic [idsc_pkg::LANES-1:0][idsc_pkg::DVS_BITS-1:0] rem_ff, rem_in;
   logic [idsc_pkg::DVS_BITS-1:0]                      dvs_ff, dvs_in;
   logic [idsc_pkg::CNT_BITS-1:0]                      cnt_ff, cnt_in;
   logic                                               busy_ff, busy_in;
   logic                                               done_ff, done_in;

   always_comb begin
      logic [idsc_pkg::DVS_BITS:0] trial;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = idsc_pkg::CNT_BITS'(idsc_pkg::DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int l = 0; l < idsc_pkg::LANES; l++) begin
            trial = {rem_ff[l], quo_ff[l][idsc_pkg::DIV_BITS-1]};
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in[l] = idsc_pkg::DVS_BITS'(trial - {1'b0, dvs_ff});
               quo_in[l] = {quo_ff[l][idsc_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[idsc_pkg::DVS_BITS-1:0];
               quo_in[l] = {quo_ff[l][idsc_pkg::DIV_BITS-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - idsc_pkg::CNT_BITS'(1);
         if (cnt_ff == idsc_pkg::CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("divider done without a finished run");

endmodule

[hw/rtl/idsc_dpath.sv]
// ----------------------------------------------------------------------------
// idsc_dpath
// Position counters, per-column accumulator memory, block decode and the
// shared divider for output scaling and quotient realignment.
// ----------------------------------------------------------------------------
module idsc_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  idsc_pkg::cmd_type                    cmd,
   input  idsc_pkg::cfg_type                    cfg,
   input  logic [idsc_pkg::PIX_BITS-1:0]        red_in,
   input  logic [idsc_pkg::PIX_BITS-1:0]        green_in,
   input  logic [idsc_pkg::PIX_BITS-1:0]        blue_in,
   output idsc_pkg::sts_type                    sts,
   output idsc_pkg::rsp_type                    rsp
);

   localparam int CB = idsc_pkg::CMP_BITS;
   localparam int FB = idsc_pkg::FACTOR_BITS;
   localparam int PB = idsc_pkg::POS_BITS;
   localparam int RB = idsc_pkg::REM_BITS;
   localparam int SB = idsc_pkg::SUM_BITS;

   // position state: column/row, quotient and remainder by factor, mod 3
   logic [PB-1:0] col_ff, col_in, colq_ff, colq_in, row_ff, row_in, rowq_ff, rowq_in;
   logic [RB-1:0] colr_ff, colr_in, rowr_ff, rowr_in, band_ff, band_in;
   logic [1:0]    colm3_ff, colm3_in, rowm3_ff, rowm3_in;

   // held item
   logic                                   hit_ff, hit_in;
   logic                                   first_ff, last_ff, rend_ff, rgb_ff;
   logic [idsc_pkg::SHIFT_BITS-1:0]        shift_ff;
   logic [idsc_pkg::OC_BITS-1:0]           addr_ff;
   logic [idsc_pkg::OUT_POS_BITS-1:0]      ocol_ff, orow_ff;
   logic [idsc_pkg::DVS_BITS-1:0]          dvs_ff;
   logic [idsc_pkg::LANES-1:0][idsc_pkg::PIX_BITS-1:0] pix_ff;

   logic [idsc_pkg::LANES*SB-1:0] sums_mem [idsc_pkg::MAX_OUT_COLUMNS];
   logic [idsc_pkg::LANES*SB-1:0] rd_ff;
   logic [idsc_pkg::LANES*SB-1:0] wr_data;

   // decode
   logic [FB-1:0]   fc, fc_m1;
   logic [2*FB-1:0] fc_sq;
   logic [PB-1:0]   col_base, row_base;
   logic [RB-1:0]   band_eff;
   logic            in_col, in_row, in_oc, first, last, row_end, col_wrap, row_wrap;
   logic [idsc_pkg::SHIFT_BITS-1:0] shift;
   logic [idsc_pkg::DVS_BITS-1:0]   dvs;

   // divider
   logic                                               div_start;
   logic [idsc_pkg::LANES-1:0][idsc_pkg::DIV_BITS-1:0] div_a, div_q;
   logic [idsc_pkg::LANES-1:0][idsc_pkg::DVS_BITS-1:0] div_r;
   logic [idsc_pkg::DVS_BITS-1:0]                      div_d;
   logic                                               div_done;

   assign fc       = cfg.factor;
   assign fc_m1    = fc - FB'(1);
   assign fc_sq    = (2*FB)'(fc) * (2*FB)'(fc);
   assign col_base = col_ff - PB'(colr_ff);
   assign row_base = row_ff - PB'(rowr_ff);
   assign band_eff = (FB'(band_ff) >= fc) ? '0 : band_ff;

   // a block is inside the cropped image when its far edge fits the size
   assign in_col  = (CB'(col_base) + CB'(fc)) <= CB'(cfg.width);
   assign in_row  = (CB'(row_base) + CB'(fc)) <= CB'(cfg.height);
   assign in_oc   = 32'(colq_ff) < idsc_pkg::MAX_OUT_COLUMNS;
   assign row_end = (CB'(col_base) + CB'({fc, 1'b0})) > CB'(cfg.width);
   assign first   = (band_eff == '0) && (colr_ff == '0);
   assign last    = (FB'(band_eff) == fc_m1) && (FB'(colr_ff) == fc_m1);
   assign shift   = fc[0] ? idsc_pkg::gauss_shift(rowm3_ff, colm3_ff) : '0;
   assign dvs     = fc[0] ? idsc_pkg::DVS_BITS'(idsc_pkg::GAUSS_DIV)
                          : fc_sq[idsc_pkg::DVS_BITS-1:0];

   assign col_wrap = (CB'(col_ff) + CB'(1)) >= CB'(cfg.width);
   assign row_wrap = (CB'(row_ff) + CB'(1)) >= CB'(cfg.height);
   assign hit_in   = in_col & in_row & in_oc;

   // counters: step on accept, realign quotients after a factor change
   always_comb begin
      col_in   = col_ff;
      colq_in  = colq_ff;
      colr_in  = colr_ff;
      colm3_in = colm3_ff;
      row_in   = row_ff;
      rowq_in  = rowq_ff;
      rowr_in  = rowr_ff;
      rowm3_in = rowm3_ff;
      band_in  = band_ff;
      if (cmd.fix_load) begin
         colq_in = div_q[0][PB-1:0];
         colr_in = div_r[0][RB-1:0];
         rowq_in = div_q[1][PB-1:0];
         rowr_in = div_r[1][RB-1:0];
      end else if (cmd.accept) begin
         if (col_wrap) begin
            col_in   = '0;
            colq_in  = '0;
            colr_in  = '0;
            colm3_in = '0;
            if (row_wrap) begin
               row_in   = '0;
               rowq_in  = '0;
               rowr_in  = '0;
               rowm3_in = '0;
               band_in  = '0;
            end else begin
               row_in   = row_ff + PB'(1);
               rowm3_in = (rowm3_ff == 2'd2) ? 2'd0 : rowm3_ff + 2'd1;
               if (FB'(rowr_ff) + FB'(1) == fc) begin
                  rowr_in = '0;
                  rowq_in = rowq_ff + PB'(1);
               end else begin
                  rowr_in = rowr_ff + RB'(1);
               end
               band_in = (FB'(band_eff) + FB'(1) >= fc) ? '0 : band_eff + RB'(1);
            end
         end else begin
            col_in   = col_ff + PB'(1);
            colm3_in = (colm3_ff == 2'd2) ? 2'd0 : colm3_ff + 2'd1;
            if (FB'(colr_ff) + FB'(1) == fc) begin
               colr_in = '0;
               colq_in = colq_ff + PB'(1);
            end else begin
               colr_in = colr_ff + RB'(1);
            end
            band_in = band_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         colq_ff  <= '0;
         colr_ff  <= '0;
         colm3_ff <= '0;
         row_ff   <= '0;
         rowq_ff  <= '0;
         rowr_ff  <= '0;
         rowm3_ff <= '0;
         band_ff  <= '0;
         hit_ff   <= 1'b0;
      end else begin
         col_ff   <= col_in;
         colq_ff  <= colq_in;
         colr_ff  <= colr_in;
         colm3_ff <= colm3_in;
         row_ff   <= row_in;
         rowq_ff  <= rowq_in;
         rowr_ff  <= rowr_in;
         rowm3_ff <= rowm3_in;
         band_ff  <= band_in;
         if (cmd.accept) hit_ff <= hit_in;
      end
   end

   // capture the item and its block decode
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         first_ff  <= first;
         last_ff   <= last;
         rend_ff   <= row_end;
         rgb_ff    <= cfg.rgb;
         shift_ff  <= shift;
         dvs_ff    <= dvs;
         addr_ff   <= idsc_pkg::OC_BITS'(colq_ff);
         ocol_ff   <= idsc_pkg::OUT_POS_BITS'(colq_ff);
         orow_ff   <= idsc_pkg::OUT_POS_BITS'(rowq_ff);
         pix_ff[0] <= red_in;
         pix_ff[1] <= cfg.rgb ? green_in : '0;
         pix_ff[2] <= cfg.rgb ? blue_in  : '0;
      end
   end

   // weighted add onto the column accumulator; a block's first pixel restarts it
   always_comb begin
      logic [SB-1:0] add;
      logic [SB-1:0] base;
      add  = '0;
      base = '0;
      for (int l = 0; l < idsc_pkg::LANES; l++) begin
         add  = SB'(pix_ff[l]) << shift_ff;
         base = first_ff ? '0 : rd_ff[l*SB +: SB];
         wr_data[l*SB +: SB] = base + add;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept)
         rd_ff <= sums_mem[idsc_pkg::OC_BITS'(colq_ff)];
      if (cmd.upd && hit_ff)
         sums_mem[addr_ff] <= wr_data;
   end

   // divider: scale finished sums, or divide column and row by a new factor
   assign div_start = (cmd.upd && hit_ff && last_ff) || cmd.fix_start;
   assign div_d     = cmd.fix_start ? idsc_pkg::DVS_BITS'(fc) : dvs_ff;

   always_comb begin
      for (int l = 0; l < idsc_pkg::LANES; l++)
         div_a[l] = idsc_pkg::DIV_BITS'(wr_data[l*SB +: SB]);
      if (cmd.fix_start) begin
         div_a[0] = idsc_pkg::DIV_BITS'(col_ff);
         div_a[1] = idsc_pkg::DIV_BITS'(row_ff);
         div_a[2] = '0;
      end
   end

   idsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_d),
      .quotient  (div_q),
      .remainder (div_r),
      .done      (div_done)
   );

   assign sts.block_done = hit_ff & last_ff;
   assign sts.div_done   = div_done;

   assign rsp.red     = div_q[0][idsc_pkg::PIX_BITS-1:0];
   assign rsp.green   = rgb_ff ? div_q[1][idsc_pkg::PIX_BITS-1:0] : '0;
   assign rsp.blue    = rgb_ff ? div_q[2][idsc_pkg::PIX_BITS-1:0] : '0;
   assign rsp.column  = ocol_ff;
   assign rsp.row     = orow_ff;
   assign rsp.row_end = rend_ff;

endmodule

[hw/rtl/idsc_ctrl.sv]
// ----------------------------------------------------------------------------
// idsc_ctrl
// Sequencer: accept a pixel, update its accumulator, run the output division
// and hold the result until taken; realign after a factor change.
// ----------------------------------------------------------------------------
module idsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 dirty,
   input  idsc_pkg::sts_type    sts,
   output idsc_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD,
      ST_DIV,
      ST_OUT,
      ST_FIX
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign req_tready = (state_ff == ST_IDLE) && !dirty;
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (dirty) begin
               cmd.fix_start = 1'b1;
               state_in      = ST_FIX;
            end else if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = sts.block_done ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               valid_in = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_FIX: begin
            if (sts.div_done) begin
               cmd.fix_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            valid_in = 1'b0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   a_accept_aligned: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !dirty)
      else $error("pixel taken before quotients were realigned");

   a_no_spurious_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && !sts.block_done) |=> state_ff == ST_IDLE)
      else $error("division run for a pixel that ends no block");

endmodule

[hw/rtl/image_block_downscaler_unit.sv]
// ----------------------------------------------------------------------------
// image_block_downscaler_unit
// Block downscaler for raster gray or RGB pixels: box average for an even
// factor, 1-2-1 Gaussian weights over 16 for an odd factor.
// ----------------------------------------------------------------------------
// Pixels enter one at a time in raster order. Each pixel is first taken while
// its output column's accumulators are read, then added and written back in
// the update state. A pixel that completes a factor-by-factor block also runs
// the shared bit-serial divider, one quotient bit per cycle, and the result
// then waits on the rsp side until taken; such a pixel occupies the block
// until its result is taken, including any rsp stall. After a write to
// scale_factor the block divides the current column and row by the new factor
// on that same divider before it takes the next pixel; writes to the other
// registers cost nothing. The accumulator memory holds one entry of three
// 20-bit sums per output column and needs no clearing: the first pixel of
// each block overwrites its entry. Columns and rows past the largest multiple
// of the factor are taken and dropped without a result.
module image_block_downscaler_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // input pixels
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] red_in, [15:8] green_in, [23:16] blue_in
   input  logic [idsc_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // downscaled pixels
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] red_out, [15:8] green_out, [23:16] blue_out,
   // [34:24] out_column, [45:35] out_row, rest zero
   output logic [idsc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // row_end: last pixel of its output row
   output logic                                 rsp_tlast,
   // register writes: 0 scale_factor, 1 image_width, 2 image_height, 3 color_mode
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [idsc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [idsc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int PXB = idsc_pkg::PIX_BITS;
   localparam int RSP_USED = 3 * PXB + 2 * idsc_pkg::OUT_POS_BITS;

   idsc_pkg::cfg_type cfg;
   idsc_pkg::cmd_type cmd;
   idsc_pkg::sts_type sts;
   idsc_pkg::rsp_type rsp;
   logic              dirty;

   // register file; flags a factor change so the sequencer realigns
   idsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fix_start (cmd.fix_start),
      .cfg       (cfg),
      .dirty     (dirty)
   );

   // sequencer: owns both handshakes
   idsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dirty      (dirty),
      .sts        (sts),
      .cmd        (cmd)
   );

   // counters, accumulators and divider
   idsc_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .red_in   (req_tdata[PXB-1:0]),
      .green_in (req_tdata[2*PXB-1:PXB]),
      .blue_in  (req_tdata[3*PXB-1:2*PXB]),
      .sts      (sts),
      .rsp      (rsp)
   );

   // pack the result, lowest field first; pad to whole bytes
   assign rsp_tdata = {{(idsc_pkg::RSP_DATA_BITS - RSP_USED){1'b0}},
                       rsp.row, rsp.column, rsp.blue, rsp.green, rsp.red};
   assign rsp_tlast = rsp.row_end;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raster frames into the image block downscaler over its stream ports,
// predicts every downscaled pixel from the pixels taken and checks each output
// item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import idsc_pkg::*;

   localparam int SETTLE_CYCLES = 48;        // covers a divide pass plus output
   localparam int LONG_HOLD     = 400;       // receiver hold-off, in cycles
   localparam int RANDOM_PIXELS = 250;
   localparam int RUN_LIMIT_NS  = 10_000_000;
   localparam int MAX_REPORTS   = 30;

   localparam int GREEN_LO = PIX_BITS;
   localparam int BLUE_LO  = 2 * PIX_BITS;
   localparam int COL_LO   = 3 * PIX_BITS;
   localparam int ROW_LO   = COL_LO + OUT_POS_BITS;

   typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_PATTERN, SINK_SPARSE} sink_mode_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the registers, accumulators and raster position;
   // predicts downscaled pixels and checks output items in order.
   // -------------------------------------------------------------------------
   class downscale_scoreboard;
      bit [FACTOR_BITS-1:0] factor_reg;
      bit [SIZE_BITS-1:0]   width_reg;
      bit [SIZE_BITS-1:0]   height_reg;
      bit                   rgb_reg;
      bit [SUM_BITS-1:0]    sums [LANES][MAX_OUT_COLUMNS];
      bit [POS_BITS-1:0]    col_pos;
      bit [POS_BITS-1:0]    row_pos;
      bit [REM_BITS-1:0]    band_pos;
      rsp_type              expected [$];
      int                   mismatches;
      int                   pixels_seen;
      int                   results_seen;

      function new();
         factor_reg = FACTOR_RESET;
         width_reg  = MAX_WIDTH;
         height_reg = MAX_WIDTH;
         rgb_reg    = 1'b0;
      endfunction

      function int unsigned fit_size(bit [SIZE_BITS-1:0] v);
         if (v == 0) return 1;
         if (v > MAX_WIDTH) return MAX_WIDTH;
         return v;
      endfunction

      function int unsigned fit_factor(bit [FACTOR_BITS-1:0] v);
         if (v < FACTOR_MIN) return FACTOR_MIN;
         if (v > FACTOR_MAX) return FACTOR_MAX;
         return v;
      endfunction

      function int unsigned frame_pixels();
         return fit_size(width_reg) * fit_size(height_reg);
      endfunction

      function int pending();
         return expected.size();
      endfunction

      function void set_reg(csr_index_type idx, bit [CSR_DATA_BITS-1:0] value);
         case (idx)
            REG_SCALE_FACTOR: factor_reg = value[FACTOR_BITS-1:0];
            REG_IMAGE_WIDTH:  width_reg  = value;
            REG_IMAGE_HEIGHT: height_reg = value;
            REG_COLOR_MODE:   rgb_reg    = value[0];
            default: ;
         endcase
      endfunction

      // accumulate one taken pixel; queue a downscaled pixel when it closes a block
      function void note_pixel(bit [REQ_DATA_BITS-1:0] word);
         int unsigned f, w, h, crop_w, crop_h, col, row, band, oc;
         int unsigned weight, divisor, add, lanes, k;
         bit opens, closes;
         rsp_type want;
         pixels_seen++;
         f      = fit_factor(factor_reg);
         w      = fit_size(width_reg);
         h      = fit_size(height_reg);
         crop_w = (w / f) * f;
         crop_h = (h / f) * f;
         col    = col_pos;
         row    = row_pos;
         band   = band_pos;
         if (band >= f) band = 0;
         lanes  = rgb_reg ? 3 : 1;
         oc     = col / f;
         if (col < crop_w && row < crop_h && oc < MAX_OUT_COLUMNS) begin
            opens  = (band == 0) && (col % f == 0);
            closes = (band == f - 1) && (col % f == f - 1);
            // odd factor: 1-2-1 kernel on absolute row and column mod 3
            if (f % 2 == 1)
               weight = ((row % 3 == 1) ? 2 : 1) * ((col % 3 == 1) ? 2 : 1);
            else
               weight = 1;
            for (k = 0; k < LANES; k++) begin
               add = (k < lanes) ? word[k*PIX_BITS +: PIX_BITS] * weight : 0;
               sums[k][oc] = SUM_BITS'((opens ? 0 : sums[k][oc]) + add);
            end
            if (closes) begin
               divisor       = (f % 2 == 1) ? GAUSS_DIV : f * f;
               want.red      = PIX_BITS'(sums[0][oc] / divisor);
               want.green    = (lanes == 3) ? PIX_BITS'(sums[1][oc] / divisor) : '0;
               want.blue     = (lanes == 3) ? PIX_BITS'(sums[2][oc] / divisor) : '0;
               want.column   = OUT_POS_BITS'(oc);
               want.row      = OUT_POS_BITS'(row / f);
               want.row_end  = (oc == crop_w / f - 1);
               expected.push_back(want);
            end
         end
         // advance the raster position; the frame wraps at the clamped size
         if (col + 1 >= w) begin
            col_pos = '0;
            if (row + 1 >= h) begin
               row_pos  = '0;
               band_pos = '0;
            end else begin
               row_pos  = POS_BITS'(row + 1);
               band_pos = (band + 1 >= f) ? '0 : REM_BITS'(band + 1);
            end
         end else begin
            col_pos  = POS_BITS'(col + 1);
            band_pos = REM_BITS'(band);
         end
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_result(logic [RSP_DATA_BITS-1:0] data, logic row_end);
         rsp_type want;
         results_seen++;
         if (expected.size() == 0) begin
            report($sformatf("output pixel with none pending, data %h", data));
            return;
         end
         want = expected.pop_front();
         if (data[PIX_BITS-1:0] !== want.red)
            report($sformatf("red got %h want %h", data[PIX_BITS-1:0], want.red));
         if (data[GREEN_LO +: PIX_BITS] !== want.green)
            report($sformatf("green got %h want %h", data[GREEN_LO +: PIX_BITS], want.green));
         if (data[BLUE_LO +: PIX_BITS] !== want.blue)
            report($sformatf("blue got %h want %h", data[BLUE_LO +: PIX_BITS], want.blue));
         if (data[COL_LO +: OUT_POS_BITS] !== want.column)
            report($sformatf("column got %0d want %0d",
                             data[COL_LO +: OUT_POS_BITS], want.column));
         if (data[ROW_LO +: OUT_POS_BITS] !== want.row)
            report($sformatf("row got %0d want %0d", data[ROW_LO +: OUT_POS_BITS], want.row));
         if (row_end !== want.row_end)
            report($sformatf("row end got %b want %b", row_end, want.row_end));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   image_block_downscaler_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   downscale_scoreboard board;
   sink_mode_type       sink_mode = SINK_OPEN;
   bit                  hold_start;      // raised by the stimulus at a rising edge
   bit                  gaps_on;
   int                  burst_left;
   int                  random_pixels;
   int                  settings_count;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: change tready at the falling edge only. A hold request from the
   // stimulus turns into a long stall counted here; otherwise follow the
   // pattern of the current phase.
   initial begin : rsp_sink
      int hold_left;
      int beat;
      hold_left  = 0;
      beat       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         beat++;
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            case (sink_mode)
               SINK_OPEN:    rsp_tready = 1'b1;
               SINK_RANDOM:  rsp_tready = ($urandom_range(0, 9) < 7);
               SINK_PATTERN: rsp_tready = ((beat % 7) < 4);
               default:      rsp_tready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Monitor: sample output items at the rising edge, pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         board.check_result(rsp_tdata, rsp_tlast);
   end

   // Offer one pixel; hold it until taken, leave tvalid high for the next one.
   task automatic push_word(bit [REQ_DATA_BITS-1:0] word);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = word;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_pixel(word);
   endtask

   // Random pixels in bursts, with idle gaps between bursts when enabled.
   task automatic stream_pixels(int count);
      int n;
      int gap;
      bit [REQ_DATA_BITS-1:0] word;
      for (n = 0; n < count; n++) begin
         if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 8);
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         if (burst_left > 0) burst_left--;
         word = REQ_DATA_BITS'($urandom());
         push_word(word);
      end
   endtask

   // Drop tvalid, wait until every predicted pixel is out, then let the block
   // finish any dropped pixel or divide pass still under way.
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, bit [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_reg(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
      settings_count++;
   endtask

   // Idle the block, pick the receiver pattern, then write all four registers.
   task automatic configure(int unsigned factor, int unsigned width, int unsigned height,
                            bit rgb, sink_mode_type sink);
      settle();
      sink_mode = sink;
      write_reg(REG_SCALE_FACTOR, CSR_DATA_BITS'(factor));
      write_reg(REG_IMAGE_WIDTH,  CSR_DATA_BITS'(width));
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(height));
      write_reg(REG_COLOR_MODE,   {12'($urandom_range(0, 4095)), rgb});
   endtask

   // One random setting: mostly small factors and frames, now and then a
   // large or out-of-range factor, zero sizes and a color switch mid-frame.
   task automatic random_phase();
      int unsigned pick, f_raw, f, w, h, frames, total;
      pick = $urandom_range(0, 19);
      if (pick == 0)      f_raw = $urandom_range(0, 1);
      else if (pick == 1) f_raw = $urandom_range(17, 31);
      else if (pick < 5)  f_raw = $urandom_range(6, 16);
      else                f_raw = $urandom_range(2, 5);
      f = board.fit_factor(FACTOR_BITS'(f_raw));
      if (f >= 8) begin
         w      = f * $urandom_range(1, 2) + $urandom_range(0, f - 1);
         h      = f + $urandom_range(0, 2);
         frames = 1;
      end else begin
         w      = f * $urandom_range(1, 4) + $urandom_range(0, f - 1);
         h      = f * $urandom_range(1, 2) + $urandom_range(0, f - 1);
         frames = $urandom_range(1, 2);
      end
      if ($urandom_range(0, 15) == 0) w = 0;
      if ($urandom_range(0, 15) == 0) h = 0;
      // upper data bits of a factor write carry no meaning
      if ($urandom_range(0, 1)) f_raw = f_raw | ($urandom_range(0, 255) << FACTOR_BITS);
      gaps_on = ($urandom_range(0, 3) != 0);
      configure(f_raw, w, h, 1'($urandom_range(0, 1)),
                sink_mode_type'($urandom_range(0, 3)));
      total = frames * board.frame_pixels();
      if ($urandom_range(0, 3) == 0) begin
         stream_pixels(total / 2);
         settle();
         write_reg(REG_COLOR_MODE, CSR_DATA_BITS'($urandom()));
         stream_pixels(total - total / 2);
      end else begin
         stream_pixels(total);
      end
      random_pixels += total;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int n;
      board          = new();
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_index      = REG_SCALE_FACTOR;
      csr_wdata      = '0;
      burst_left     = 0;
      random_pixels  = 0;
      settings_count = 0;
      gaps_on        = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: 2x2 box on a 4x2 frame, first row gray, then switch to RGB
      // mid-frame so green and blue hold only the second row.
      configure(2, 4, 2, 1'b0, SINK_OPEN);
      push_word(24'h3412FF);
      push_word(24'h7856FF);
      push_word(24'hBC9A00);
      push_word(24'hF0DE01);
      settle();
      write_reg(REG_COLOR_MODE, CSR_DATA_BITS'(1));
      push_word(24'hFFFFFF);
      push_word(24'hFF00FE);
      push_word(24'h00FF00);
      push_word(24'h018000);

      // Directed: Gaussian 3x3 at full scale in RGB, last column cropped;
      // the factor write carries junk in its upper bits.
      gaps_on = 1'b1;
      configure(13'h1FE3, 4, 3, 1'b1, SINK_PATTERN);
      for (n = 0; n < 12; n++)
         push_word((n % 4 == 3) ? 24'($urandom()) : 24'hFFFFFF);

      // Directed: factor and width below range; frame of one column, no output.
      configure(0, 0, 2, 1'b0, SINK_RANDOM);
      push_word(24'h000000);
      push_word(24'hFFFFFF);

      // Height shrinks mid-frame: the next row ends the frame, then a new one.
      configure(2, 4, 8, 1'b1, SINK_RANDOM);
      stream_pixels(8);
      settle();
      write_reg(REG_IMAGE_HEIGHT, CSR_DATA_BITS'(2));
      stream_pixels(12);

      // Factor changes mid-frame on a band boundary: 2 for four rows, then 4.
      configure(2, 6, 8, 1'b0, SINK_PATTERN);
      stream_pixels(24);
      settle();
      write_reg(REG_SCALE_FACTOR, CSR_DATA_BITS'(4));
      stream_pixels(24);

      // Back-pressure: receiver holds off while the sender keeps offering.
      gaps_on = 1'b0;
      configure(2, 8, 4, 1'b1, SINK_OPEN);
      @(posedge clock);
      hold_start = 1'b1;
      stream_pixels(32);

      while (random_pixels < RANDOM_PIXELS) random_phase();

      settle();
      $display("covered %0d pixels over %0d register writes, %0d output pixels checked",
               board.pixels_seen, settings_count, board.results_seen);
      $display("box and Gaussian factors, gray and RGB, clamped and cropped sizes, %s",
               "mid-frame writes, long output stall");
      if (board.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", board.mismatches);
         $display("TB_ERROR");
      end
      $finish;
   end

   // Hard stop well past the slowest correct run.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("timeout with %0d output pixels pending", board.pending());
      $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/idsc_pkg.sv
hw/rtl/idsc_csr.sv
hw/rtl/idsc_div.sv
hw/rtl/idsc_dpath.sv
hw/rtl/idsc_ctrl.sv
hw/rtl/image_block_downscaler_unit.sv
sim/testbench.sv
